// ===== design/mvna_pkg.sv =====
// Shared types and constants for the mesh vertex normal accumulator.
// Used by every design file and the port checker; depends on nothing.
`timescale 1ns / 1ps

package mvna_pkg;

  localparam int VERTEX_COUNT_MAX_DEF = 4096;
  localparam int POSITION_BITS_DEF = 16;
  localparam int INDEX_BITS = 12;
  localparam int IN_POS_BITS = 16;
  localparam int SUM_BITS = 40;
  localparam int FRAC_OUT = 14;
  localparam int OUT_BITS = 16;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_TRI   = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  typedef logic signed [SUM_BITS-1:0] sum_t;
  typedef logic signed [OUT_BITS-1:0] norm_t;

endpackage

// ===== design/mvna_store.sv =====
// Position memory and normal accumulator memory, one write and one read port each.
// Read data is registered. Depends on mvna_pkg.
`timescale 1ns / 1ps

module mvna_store #(
  parameter int VERTEX_COUNT_MAX = mvna_pkg::VERTEX_COUNT_MAX_DEF,
  parameter int POSITION_BITS = mvna_pkg::POSITION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   pos_we,
  input  logic [$clog2(VERTEX_COUNT_MAX)-1:0]     pos_waddr,
  input  logic [3*POSITION_BITS-1:0]              pos_wdata,
  input  logic [$clog2(VERTEX_COUNT_MAX)-1:0]     pos_raddr,
  output logic [3*POSITION_BITS-1:0]              pos_rdata,
  input  logic                                   sum_we,
  input  logic [$clog2(VERTEX_COUNT_MAX)-1:0]     sum_waddr,
  input  logic [3*mvna_pkg::SUM_BITS-1:0]         sum_wdata,
  input  logic [$clog2(VERTEX_COUNT_MAX)-1:0]     sum_raddr,
  output logic [3*mvna_pkg::SUM_BITS-1:0]         sum_rdata
);

  logic [3*POSITION_BITS-1:0]      pos_mem [VERTEX_COUNT_MAX];
  logic [3*mvna_pkg::SUM_BITS-1:0] sum_mem [VERTEX_COUNT_MAX];
  logic [3*POSITION_BITS-1:0]      pos_rdata_r;
  logic [3*mvna_pkg::SUM_BITS-1:0] sum_rdata_r;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rdata_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rdata_r <= sum_mem[sum_raddr];
  end

  assign pos_rdata = pos_rdata_r;
  assign sum_rdata = sum_rdata_r;

endmodule

// ===== design/mvna_norm.sv =====
// Iterative normalizer: scales a 40-bit sum vector to a Q1.14 unit vector.
// One shift, one square, one root step or one quotient bit per cycle. Depends on mvna_pkg.
`timescale 1ns / 1ps

module mvna_norm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  mvna_pkg::sum_t   sum_x,
  input  mvna_pkg::sum_t   sum_y,
  input  mvna_pkg::sum_t   sum_z,
  output logic             done,
  output mvna_pkg::norm_t  norm_x,
  output mvna_pkg::norm_t  norm_y,
  output mvna_pkg::norm_t  norm_z,
  output logic             zero_length
);

  localparam int SW = mvna_pkg::SUM_BITS;
  localparam int FO = mvna_pkg::FRAC_OUT;
  localparam int QW = FO + 1;
  localparam int RW = 31 + FO;

  typedef enum logic [2:0] {
    N_IDLE, N_SCALE, N_SQ, N_ROOT, N_DSET, N_DIV
  } nstate_t;

  nstate_t               state_r;
  logic [SW-1:0]         t_r [3];
  logic [2:0]            neg_r;
  logic [SW-1:0]         m_r;
  logic [1:0]            c_r;
  logic [61:0]           acc_r;
  logic [62:0]           root_r;
  logic [4:0]            k_r;
  logic [30:0]           len_r;
  logic [RW-1:0]         rem_r;
  logic [RW-1:0]         div_r;
  logic [QW-2:0]         q_r;
  logic [3:0]            i_r;
  logic                  done_r;
  logic                  zero_r;
  mvna_pkg::norm_t       out_r [3];

  logic [SW-1:0]         mag_x, mag_y, mag_z, m_xy, m_max;
  logic [59:0]           sq_prod;
  logic [62:0]           bit_w, trial;
  logic                  root_ge;
  logic [62:0]           root_nxt;
  logic                  div_ge;
  logic [QW-1:0]         q_fin;
  mvna_pkg::norm_t       q_signed;

  always_comb begin
    mag_x = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
    mag_y = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
    mag_z = sum_z[SW-1] ? SW'(-sum_z) : SW'(sum_z);
    m_xy = (mag_y > mag_x) ? mag_y : mag_x;
    m_max = (mag_z > m_xy) ? mag_z : m_xy;
    sq_prod = t_r[c_r][29:0] * t_r[c_r][29:0];
    bit_w = 63'(1) << {k_r, 1'b0};
    trial = root_r + bit_w;
    root_ge = {1'b0, acc_r} >= trial;
    root_nxt = root_ge ? ((root_r >> 1) + bit_w) : (root_r >> 1);
    div_ge = rem_r >= div_r;
    q_fin = {q_r, div_ge};
    q_signed = neg_r[c_r] ? mvna_pkg::norm_t'(-{1'b0, q_fin})
                          : mvna_pkg::norm_t'({1'b0, q_fin});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            t_r[0] <= mag_x;
            t_r[1] <= mag_y;
            t_r[2] <= mag_z;
            neg_r <= {sum_z[SW-1], sum_y[SW-1], sum_x[SW-1]};
            m_r <= m_max;
            if (m_max == '0) begin
              out_r[0] <= '0;
              out_r[1] <= '0;
              out_r[2] <= '0;
              zero_r <= 1'b1;
              done_r <= 1'b1;
            end else begin
              state_r <= N_SCALE;
            end
          end
        end
        N_SCALE: begin
          // Bring the largest magnitude into [2^29, 2^30), one bit per cycle.
          if (m_r[SW-1:30] != '0) begin
            m_r <= m_r >> 1;
            t_r[0] <= t_r[0] >> 1;
            t_r[1] <= t_r[1] >> 1;
            t_r[2] <= t_r[2] >> 1;
          end else if (!m_r[29]) begin
            m_r <= m_r << 1;
            t_r[0] <= t_r[0] << 1;
            t_r[1] <= t_r[1] << 1;
            t_r[2] <= t_r[2] << 1;
          end else begin
            acc_r <= '0;
            c_r <= 2'd0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          acc_r <= acc_r + 62'(sq_prod);
          if (c_r == 2'd2) begin
            root_r <= '0;
            k_r <= 5'd31;
            state_r <= N_ROOT;
          end else begin
            c_r <= c_r + 2'd1;
          end
        end
        N_ROOT: begin
          if (root_ge) begin
            acc_r <= 62'({1'b0, acc_r} - trial);
          end
          root_r <= root_nxt;
          k_r <= k_r - 5'd1;
          if (k_r == 5'd0) begin
            len_r <= root_nxt[30:0];
            c_r <= 2'd0;
            state_r <= N_DSET;
          end
        end
        N_DSET: begin
          rem_r <= RW'({t_r[c_r][29:0], FO'(0)}) + RW'(len_r >> 1);
          div_r <= RW'({len_r, FO'(0)});
          q_r <= '0;
          i_r <= 4'(FO);
          state_r <= N_DIV;
        end
        N_DIV: begin
          if (div_ge) begin
            rem_r <= rem_r - div_r;
          end
          div_r <= div_r >> 1;
          q_r <= q_fin[QW-2:0];
          i_r <= i_r - 4'd1;
          if (i_r == 4'd0) begin
            out_r[c_r] <= q_signed;
            if (c_r == 2'd2) begin
              zero_r <= 1'b0;
              done_r <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              c_r <= c_r + 2'd1;
              state_r <= N_DSET;
            end
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign norm_x = out_r[0];
  assign norm_y = out_r[1];
  assign norm_z = out_r[2];
  assign zero_length = zero_r;

endmodule

// ===== design/mesh_vertex_normal_accumulator.sv =====
// Top level of the area-weighted vertex normal accumulator: command sequencer,
// shared cross-product multiplier, memories and normalizer. Depends on mvna_pkg,
// mvna_store and mvna_norm.
//
// Usage: a command beat is taken when start is high and busy is low. Write
// (func 0) stores a position and clears that vertex's sum in the accept cycle,
// so busy stays low. Triangle (func 1) reads three positions, forms the cross
// product with one multiplier and does three read-modify-writes of the sums,
// with busy high throughout. Read (func 2) fetches a sum and runs the
// normalizer: a scaling phase of at most 29 shifts, 3 squares, 32 root steps
// and three divides; the result appears as a one-cycle out_valid beat. A zero
// sum or an out-of-range read answers with a zero normal and out_zero_length set.
// After reset the block clears all VERTEX_COUNT_MAX sums, one per cycle, with
// busy high. The receiver cannot stall; each out_valid beat is taken as shown.
`timescale 1ns / 1ps

module mesh_vertex_normal_accumulator #(
  parameter int VERTEX_COUNT_MAX = mvna_pkg::VERTEX_COUNT_MAX_DEF,
  parameter int POSITION_BITS = mvna_pkg::POSITION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_func,
  input  logic [mvna_pkg::INDEX_BITS-1:0]        in_vertex_a,
  input  logic [mvna_pkg::INDEX_BITS-1:0]        in_vertex_b,
  input  logic [mvna_pkg::INDEX_BITS-1:0]        in_vertex_c,
  input  logic signed [mvna_pkg::IN_POS_BITS-1:0] in_pos_x,
  input  logic signed [mvna_pkg::IN_POS_BITS-1:0] in_pos_y,
  input  logic signed [mvna_pkg::IN_POS_BITS-1:0] in_pos_z,
  output logic                                   out_valid,
  output mvna_pkg::norm_t                        out_normal_x,
  output mvna_pkg::norm_t                        out_normal_y,
  output mvna_pkg::norm_t                        out_normal_z,
  output logic                                   out_zero_length
);

  localparam int AW = $clog2(VERTEX_COUNT_MAX);
  localparam int PB = POSITION_BITS;
  localparam int DB = PB + 1;
  localparam int SW = mvna_pkg::SUM_BITS;
  localparam int XW = mvna_pkg::INDEX_BITS + 18;
  localparam logic [XW-1:0] VCM_L = XW'(VERTEX_COUNT_MAX);
  localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_COUNT_MAX - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RA, S_RB, S_RC, S_LC, S_MUL, S_RMW_RD, S_RMW_WR,
    S_RDS, S_NSTART, S_NWAIT, S_ZERO
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         clr_r;
  logic [AW-1:0]         va_r, vb_r, vc_r;
  logic [3*PB-1:0]       pa_r, pb_r;
  logic signed [DB-1:0]  ab_r [3];
  logic signed [DB-1:0]  ac_r [3];
  logic [2:0]            k_r;
  logic [1:0]            j_r;
  mvna_pkg::sum_t        acc_r;
  mvna_pkg::sum_t        cross_r [3];
  logic                  out_valid_r;
  mvna_pkg::norm_t       out_x_r, out_y_r, out_z_r;
  logic                  out_zero_r;

  logic                  accept;
  logic                  a_ok, b_ok, c_ok;
  logic                  pos_we;
  logic [AW-1:0]         pos_raddr;
  logic [3*PB-1:0]       pos_wdata, pos_rdata;
  logic                  sum_we;
  logic [AW-1:0]         sum_waddr, sum_raddr, v_sel;
  logic [3*SW-1:0]       sum_wdata, sum_rdata;
  logic signed [DB-1:0]  op_a, op_b;
  logic signed [2*DB-1:0] prod;
  mvna_pkg::sum_t        prod_s;
  logic                  norm_start, norm_done, norm_zero;
  mvna_pkg::norm_t       norm_x, norm_y, norm_z;

  assign accept = start && (state_r == S_IDLE);
  assign a_ok = XW'(in_vertex_a) < VCM_L;
  assign b_ok = XW'(in_vertex_b) < VCM_L;
  assign c_ok = XW'(in_vertex_c) < VCM_L;
  assign pos_we = accept && (in_func == mvna_pkg::FUNC_WRITE) && a_ok;
  assign pos_wdata = {PB'(in_pos_z), PB'(in_pos_y), PB'(in_pos_x)};
  assign norm_start = (state_r == S_NSTART);

  always_comb begin
    unique case (j_r)
      2'd0: v_sel = va_r;
      2'd1: v_sel = vb_r;
      default: v_sel = vc_r;
    endcase
  end

  always_comb begin
    pos_raddr = va_r;
    if (state_r == S_RB) begin
      pos_raddr = vb_r;
    end else if (state_r == S_RC) begin
      pos_raddr = vc_r;
    end
  end

  always_comb begin
    sum_we = 1'b0;
    sum_waddr = AW'(in_vertex_a);
    sum_wdata = '0;
    sum_raddr = (state_r == S_RDS) ? va_r : v_sel;
    if (state_r == S_CLEAR) begin
      sum_we = 1'b1;
      sum_waddr = clr_r;
    end else if (state_r == S_RMW_WR) begin
      sum_we = 1'b1;
      sum_waddr = v_sel;
      sum_wdata = {SW'(sum_rdata[3*SW-1:2*SW] + cross_r[2]),
                   SW'(sum_rdata[2*SW-1:SW] + cross_r[1]),
                   SW'(sum_rdata[SW-1:0] + cross_r[0])};
    end else if (pos_we) begin
      sum_we = 1'b1;
    end
  end

  // Cross product terms in multiply order: y*z, z*y, z*x, x*z, x*y, y*x.
  always_comb begin
    unique case (k_r)
      3'd0: begin op_a = ab_r[1]; op_b = ac_r[2]; end
      3'd1: begin op_a = ab_r[2]; op_b = ac_r[1]; end
      3'd2: begin op_a = ab_r[2]; op_b = ac_r[0]; end
      3'd3: begin op_a = ab_r[0]; op_b = ac_r[2]; end
      3'd4: begin op_a = ab_r[0]; op_b = ac_r[1]; end
      default: begin op_a = ab_r[1]; op_b = ac_r[0]; end
    endcase
    prod = op_a * op_b;
    prod_s = SW'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LAST_ADDR) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          va_r <= AW'(in_vertex_a);
          vb_r <= AW'(in_vertex_b);
          vc_r <= AW'(in_vertex_c);
          if (start) begin
            case (in_func)
              mvna_pkg::FUNC_TRI: begin
                if (a_ok && b_ok && c_ok) begin
                  state_r <= S_RA;
                end
              end
              mvna_pkg::FUNC_READ: state_r <= a_ok ? S_RDS : S_ZERO;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_RA: state_r <= S_RB;
        S_RB: begin
          pa_r <= pos_rdata;
          state_r <= S_RC;
        end
        S_RC: begin
          pb_r <= pos_rdata;
          state_r <= S_LC;
        end
        S_LC: begin
          ab_r[0] <= DB'($signed(pb_r[PB-1:0])) - DB'($signed(pa_r[PB-1:0]));
          ab_r[1] <= DB'($signed(pb_r[2*PB-1:PB])) - DB'($signed(pa_r[2*PB-1:PB]));
          ab_r[2] <= DB'($signed(pb_r[3*PB-1:2*PB])) - DB'($signed(pa_r[3*PB-1:2*PB]));
          ac_r[0] <= DB'($signed(pos_rdata[PB-1:0])) - DB'($signed(pa_r[PB-1:0]));
          ac_r[1] <= DB'($signed(pos_rdata[2*PB-1:PB]))
                     - DB'($signed(pa_r[2*PB-1:PB]));
          ac_r[2] <= DB'($signed(pos_rdata[3*PB-1:2*PB]))
                     - DB'($signed(pa_r[3*PB-1:2*PB]));
          k_r <= 3'd0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (!k_r[0]) begin
            acc_r <= prod_s;
          end else begin
            cross_r[k_r[2:1]] <= acc_r - prod_s;
          end
          k_r <= k_r + 3'd1;
          if (k_r == 3'd5) begin
            j_r <= 2'd0;
            state_r <= S_RMW_RD;
          end
        end
        S_RMW_RD: state_r <= S_RMW_WR;
        S_RMW_WR: begin
          j_r <= j_r + 2'd1;
          state_r <= (j_r == 2'd2) ? S_IDLE : S_RMW_RD;
        end
        S_RDS: state_r <= S_NSTART;
        S_NSTART: state_r <= S_NWAIT;
        S_NWAIT: begin
          if (norm_done) begin
            out_x_r <= norm_x;
            out_y_r <= norm_y;
            out_z_r <= norm_z;
            out_zero_r <= norm_zero;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_ZERO: begin
          out_x_r <= '0;
          out_y_r <= '0;
          out_z_r <= '0;
          out_zero_r <= 1'b1;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  mvna_store #(
    .VERTEX_COUNT_MAX(VERTEX_COUNT_MAX),
    .POSITION_BITS(POSITION_BITS)
  ) u_store (
    .clk(clk),
    .pos_we(pos_we),
    .pos_waddr(AW'(in_vertex_a)),
    .pos_wdata(pos_wdata),
    .pos_raddr(pos_raddr),
    .pos_rdata(pos_rdata),
    .sum_we(sum_we),
    .sum_waddr(sum_waddr),
    .sum_wdata(sum_wdata),
    .sum_raddr(sum_raddr),
    .sum_rdata(sum_rdata)
  );

  mvna_norm u_norm (
    .clk(clk),
    .rst_n(rst_n),
    .start(norm_start),
    .sum_x(sum_rdata[SW-1:0]),
    .sum_y(sum_rdata[2*SW-1:SW]),
    .sum_z(sum_rdata[3*SW-1:2*SW]),
    .done(norm_done),
    .norm_x(norm_x),
    .norm_y(norm_y),
    .norm_z(norm_z),
    .zero_length(norm_zero)
  );

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_normal_x = out_x_r;
  assign out_normal_y = out_y_r;
  assign out_normal_z = out_z_r;
  assign out_zero_length = out_zero_r;

endmodule

// ===== design/mvna_checker.sv =====
// Port-level checks for the vertex normal accumulator, bound to the top level.
// Depends on mvna_pkg and mesh_vertex_normal_accumulator.
`timescale 1ns / 1ps

module mvna_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic [1:0]                             in_func,
  input logic                                   out_valid,
  input mvna_pkg::norm_t                        out_normal_x,
  input mvna_pkg::norm_t                        out_normal_y,
  input mvna_pkg::norm_t                        out_normal_z,
  input logic                                   out_zero_length
);

  // Result beats never come back to back; each follows work in the sequencer.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat lasted more than one cycle");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == mvna_pkg::FUNC_TRI || in_func == mvna_pkg::FUNC_READ))
      |=> busy)
    else $error("triangle or read beat did not raise busy");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |->
      (out_normal_x == 0 && out_normal_y == 0 && out_normal_z == 0))
    else $error("zero-length result carries a nonzero normal");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_length) |->
      (out_normal_x != 0 || out_normal_y != 0 || out_normal_z != 0))
    else $error("normalized result is all zero");

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_mvna_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_func(in_func),
  .out_valid(out_valid),
  .out_normal_x(out_normal_x),
  .out_normal_y(out_normal_y),
  .out_normal_z(out_normal_z),
  .out_zero_length(out_zero_length)
);
